### rtl/wsfa_pkg.sv
// ----------------------------------------------------------------------------
// wsfa_pkg
// Shared types, codes and fixed-point helpers of the structure factor
// accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsfa_pkg;

  // command kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_NORM   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // configuration register indexes
  localparam logic REG_KPOINT_COUNT  = 1'b0;
  localparam logic REG_SPECIES_COUNT = 1'b1;

  localparam int MUL_W   = 32;
  localparam int ACC_W   = 96;
  localparam int PW_W    = 63;
  localparam int DEN_W   = 64;
  localparam int ENTRY_W = PW_W + 2 * DEN_W;
  localparam int SUM_W   = 35;
  localparam int WGT_W   = 20;
  localparam int WT_W    = 48;

  // partial product placement in the accumulator
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  localparam logic [PW_W-1:0]  POWER_MAX = '1;
  localparam logic [DEN_W-1:0] DEN_MAX   = {1'b0, {(DEN_W-1){1'b1}}};
  localparam logic [DEN_W-1:0] DEN_MIN   = {1'b1, {(DEN_W-1){1'b0}}};

  typedef struct packed {
    logic       issue;
    logic       clr;
    logic [1:0] shift;
  } macc_ctl_t;

  function automatic logic [DEN_W-1:0] mag64(logic [DEN_W-1:0] v);
    return v[DEN_W-1] ? (64'd0 - v) : v;
  endfunction

  // power entry times scale, 16 fraction bits dropped, saturating
  function automatic logic [PW_W-1:0] pw_scale(logic [ACC_W-1:0] p);
    if (|p[ACC_W-1:79]) begin
      return POWER_MAX;
    end
    return p[78:16];
  endfunction

  // magnitude product back to signed, 16 fraction bits dropped, saturating
  function automatic logic [DEN_W-1:0] dens_scale(logic neg, logic [ACC_W-1:0] p);
    logic [DEN_W-1:0] r;
    r = p[79:16];
    if ((|p[ACC_W-1:80]) || r[DEN_W-1]) begin
      return neg ? DEN_MIN : DEN_MAX;
    end
    return neg ? (64'd0 - r) : r;
  endfunction

  function automatic logic [DEN_W-1:0] sat_add64(logic [DEN_W-1:0] a, logic [DEN_W-1:0] b);
    logic [DEN_W:0] s;
    s = {a[DEN_W-1], a} + {b[DEN_W-1], b};
    if (s[DEN_W] != s[DEN_W-1]) begin
      return s[DEN_W] ? DEN_MIN : DEN_MAX;
    end
    return s[DEN_W-1:0];
  endfunction

endpackage

### rtl/weighted_structure_factor_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_structure_factor_accumulator
// Accumulates weighted structure factor power and density per k-point.
// A command is taken when start_i is high and busy_o is low. A sample that
// is not the last species is taken without leaving idle; the last species
// commits to its k-point through the shared 32x32 multiplier, which runs 15
// partial products. A read result is registered through the read state and
// then valid_o, shown for exactly one cycle; the receiver cannot stall it.
// Normalize sweeps the store one k-point at a time, clear writes one k-point
// a cycle. After reset the store is zeroed by the same pass with busy_o
// high; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_structure_factor_accumulator #(
  parameter int MAX_KPOINTS = 1024,
  parameter int MAX_SPECIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic [9:0]         kpoint_i,
  input  logic [2:0]         species_i,
  input  logic signed [31:0] rho_real_i,
  input  logic signed [31:0] rho_imag_i,
  input  logic [19:0]        weight_i,
  input  logic [31:0]        scale_i,
  output logic               valid_o,
  output logic [62:0]        power_sum_o,
  output logic signed [63:0] density_sum_real_o,
  output logic signed [63:0] density_sum_imag_o,
  output logic [47:0]        weight_total_o
);

  import wsfa_pkg::*;

  localparam int KW  = (MAX_KPOINTS > 1) ? $clog2(MAX_KPOINTS) : 1;
  localparam int KCW = $clog2(MAX_KPOINTS + 1);
  localparam int SCW = $clog2(MAX_SPECIES + 1);
  localparam logic [KW-1:0] LAST_IDX = KW'(MAX_KPOINTS - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CMT  = 3'd2;
  localparam logic [2:0] ST_NRM  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;

  localparam logic [4:0] CMT_LAST = 5'd16;
  localparam logic [4:0] NRM_LAST = 5'd8;

  logic [2:0]            state_q, state_d;
  logic [4:0]            step_q, step_d;
  logic [KW-1:0]         idx_q, idx_d;
  logic                  valid_q, valid_d;
  logic [10:0]           kpoint_count_q;
  logic [3:0]            species_count_q;
  logic signed [SUM_W-1:0] sum_re_q, sum_re_d, sum_im_q, sum_im_d;
  logic [WT_W-1:0]       wt_q, wt_d;

  logic [KW-1:0]         kaddr_q, kaddr_d;
  logic [WGT_W-1:0]      w_q, w_d;
  logic [31:0]           f_q, f_d;
  logic                  last_k_q, last_k_d;
  logic                  oob_q, oob_d;
  logic [70:0]           sq_q, sq_d;
  logic [38:0]           prw_re_q, prw_re_d, prw_im_q, prw_im_d;
  logic [PW_W-1:0]       npw_q, npw_d;
  logic [DEN_W-1:0]      ndre_q, ndre_d;
  logic [PW_W-1:0]       pw_out_q, pw_out_d;
  logic [DEN_W-1:0]      dre_out_q, dre_out_d, dim_out_q, dim_out_d;
  logic [WT_W-1:0]       wt_out_q, wt_out_d;

  logic [KCW-1:0]        kc_eff;
  logic [SCW-1:0]        sc_eff;
  logic [31:0]           kp32;
  logic [KW-1:0]         kp_addr;
  logic                  samp_ok, last_s, last_k, kp_in_range;
  logic signed [SUM_W:0] add_re, add_im;
  logic [SUM_W-1:0]      mre, mim;
  logic [MUL_W-1:0]      w32;

  logic                  ram_we, ram_re;
  logic [KW-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [PW_W-1:0]       rd_pw;
  logic [DEN_W-1:0]      rd_dre, rd_dim, mdre, mdim;

  macc_ctl_t             mctl;
  logic [MUL_W-1:0]      ma, mb;
  logic [ACC_W-1:0]      acc;

  logic [DEN_W-1:0]      pw_sum;
  logic [DEN_W-1:0]      dre_add, dim_add;
  logic [WT_W:0]         wt_sum;

  // effective register values
  always_comb begin
    if (kpoint_count_q == '0) begin
      kc_eff = KCW'(1);
    end else if (32'(kpoint_count_q) > 32'(MAX_KPOINTS)) begin
      kc_eff = KCW'(MAX_KPOINTS);
    end else begin
      kc_eff = KCW'(kpoint_count_q);
    end
    if (species_count_q == '0) begin
      sc_eff = SCW'(1);
    end else if (32'(species_count_q) > 32'(MAX_SPECIES)) begin
      sc_eff = SCW'(MAX_SPECIES);
    end else begin
      sc_eff = SCW'(species_count_q);
    end
  end

  assign kp32        = 32'(kpoint_i);
  assign kp_addr     = kp32[KW-1:0];
  assign kp_in_range = kp32 < 32'(MAX_KPOINTS);
  assign samp_ok     = (kp32 < 32'(kc_eff)) && (32'(species_i) < 32'(sc_eff));
  assign last_s      = (32'(species_i) + 32'd1) == 32'(sc_eff);
  assign last_k      = (kp32 + 32'd1) == 32'(kc_eff);

  assign add_re = (SUM_W+1)'(sum_re_q) + (SUM_W+1)'(rho_real_i);
  assign add_im = (SUM_W+1)'(sum_im_q) + (SUM_W+1)'(rho_imag_i);

  assign mre = sum_re_q[SUM_W-1] ? SUM_W'(-sum_re_q) : SUM_W'(sum_re_q);
  assign mim = sum_im_q[SUM_W-1] ? SUM_W'(-sum_im_q) : SUM_W'(sum_im_q);
  assign w32 = MUL_W'(w_q);

  assign rd_pw  = ram_rdata[ENTRY_W-1 -: PW_W];
  assign rd_dre = ram_rdata[2*DEN_W-1 -: DEN_W];
  assign rd_dim = ram_rdata[DEN_W-1:0];
  assign mdre   = mag64(rd_dre);
  assign mdim   = mag64(rd_dim);

  // commit arithmetic
  assign pw_sum  = {1'b0, rd_pw} + DEN_W'(acc[89:32]);
  assign dre_add = sum_re_q[SUM_W-1] ? (64'd0 - DEN_W'(prw_re_q)) : DEN_W'(prw_re_q);
  assign dim_add = sum_im_q[SUM_W-1] ? (64'd0 - DEN_W'(prw_im_q)) : DEN_W'(prw_im_q);
  assign wt_sum  = {1'b0, wt_q} + (WT_W+1)'(w_q);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    idx_d     = idx_q;
    valid_d   = 1'b0;
    sum_re_d  = sum_re_q;
    sum_im_d  = sum_im_q;
    wt_d      = wt_q;
    kaddr_d   = kaddr_q;
    w_d       = w_q;
    f_d       = f_q;
    last_k_d  = last_k_q;
    oob_d     = oob_q;
    sq_d      = sq_q;
    prw_re_d  = prw_re_q;
    prw_im_d  = prw_im_q;
    npw_d     = npw_q;
    ndre_d    = ndre_q;
    pw_out_d  = pw_out_q;
    dre_out_d = dre_out_q;
    dim_out_d = dim_out_q;
    wt_out_d  = wt_out_q;
    ram_we    = 1'b0;
    ram_waddr = (state_q == ST_CMT) ? kaddr_q : idx_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = (state_q == ST_NRM) ? idx_q : kp_addr;
    mctl      = '0;
    ma        = '0;
    mb        = '0;

    case (state_q)
      ST_CLR: begin
        ram_we = 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            KIND_SAMPLE: begin
              ram_re = 1'b1;
              if (samp_ok) begin
                if (species_i == '0) begin
                  sum_re_d = SUM_W'(rho_real_i);
                  sum_im_d = SUM_W'(rho_imag_i);
                end else begin
                  if (add_re[SUM_W] != add_re[SUM_W-1]) begin
                    sum_re_d = add_re[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
                  end else begin
                    sum_re_d = add_re[SUM_W-1:0];
                  end
                  if (add_im[SUM_W] != add_im[SUM_W-1]) begin
                    sum_im_d = add_im[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
                  end else begin
                    sum_im_d = add_im[SUM_W-1:0];
                  end
                end
                if (last_s) begin
                  state_d  = ST_CMT;
                  step_d   = '0;
                  kaddr_d  = kp_addr;
                  w_d      = weight_i;
                  last_k_d = last_k;
                end
              end
            end
            KIND_NORM: begin
              state_d = ST_NRM;
              step_d  = '0;
              idx_d   = '0;
              f_d     = scale_i;
              wt_d    = '0;
            end
            KIND_CLEAR: begin
              state_d = ST_CLR;
              idx_d   = '0;
            end
            KIND_READ: begin
              ram_re  = 1'b1;
              oob_d   = !kp_in_range;
              state_d = ST_RD;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RD: begin
        valid_d   = 1'b1;
        pw_out_d  = oob_q ? '0 : rd_pw;
        dre_out_d = oob_q ? '0 : rd_dre;
        dim_out_d = oob_q ? '0 : rd_dim;
        wt_out_d  = wt_q;
        state_d   = ST_IDLE;
      end

      ST_CMT: begin
        step_d = step_q + 1'b1;
        case (step_q)
          // squared magnitudes, sum of both
          5'd0: begin
            mctl = '{1'b1, 1'b1, SH_0};  ma = mre[31:0];          mb = mre[31:0];
          end
          5'd1: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = MUL_W'(mre[34:32]); mb = mre[31:0];
          end
          5'd2: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = mre[31:0];          mb = MUL_W'(mre[34:32]);
          end
          5'd3: begin
            mctl = '{1'b1, 1'b0, SH_64}; ma = MUL_W'(mre[34:32]); mb = MUL_W'(mre[34:32]);
          end
          5'd4: begin
            mctl = '{1'b1, 1'b0, SH_0};  ma = mim[31:0];          mb = mim[31:0];
          end
          5'd5: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = MUL_W'(mim[34:32]); mb = mim[31:0];
          end
          5'd6: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = mim[31:0];          mb = MUL_W'(mim[34:32]);
          end
          5'd7: begin
            mctl = '{1'b1, 1'b0, SH_64}; ma = MUL_W'(mim[34:32]); mb = MUL_W'(mim[34:32]);
          end
          // weighted density magnitudes
          5'd8: begin
            mctl = '{1'b1, 1'b1, SH_0};  ma = mre[31:0];          mb = w32;
          end
          5'd9: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = MUL_W'(mre[34:32]); mb = w32;
            sq_d = acc[70:0];
          end
          5'd10: begin
            mctl = '{1'b1, 1'b1, SH_0};  ma = mim[31:0];          mb = w32;
          end
          5'd11: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = MUL_W'(mim[34:32]); mb = w32;
            prw_re_d = acc[54:16];
          end
          // weighted power
          5'd12: begin
            mctl = '{1'b1, 1'b1, SH_0};  ma = sq_q[31:0];         mb = w32;
          end
          5'd13: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = sq_q[63:32];        mb = w32;
            prw_im_d = acc[54:16];
          end
          5'd14: begin
            mctl = '{1'b1, 1'b0, SH_64}; ma = MUL_W'(sq_q[70:64]); mb = w32;
          end
          CMT_LAST: begin
            ram_we    = 1'b1;
            ram_wdata = {(pw_sum[DEN_W-1] ? POWER_MAX : pw_sum[PW_W-1:0]),
                         sat_add64(rd_dre, dre_add),
                         sat_add64(rd_dim, dim_add)};
            if (last_k_q) begin
              wt_d = wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
            end
            step_d  = '0;
            state_d = ST_IDLE;
          end
          default: begin
          end
        endcase
      end

      ST_NRM: begin
        step_d = step_q + 1'b1;
        case (step_q)
          5'd0: begin
            ram_re = 1'b1;
          end
          5'd1: begin
            mctl = '{1'b1, 1'b1, SH_0};  ma = rd_pw[31:0];           mb = f_q;
          end
          5'd2: begin
            mctl = '{1'b1, 1'b0, SH_32}; ma = MUL_W'(rd_pw[62:32]);  mb = f_q;
          end
          5'd3: begin
            mctl = '{1'b1, 1'b1, SH_0};  ma = mdre[31:0];            mb = f_q;
          end
          5'd4: begin
            mctl  = '{1'b1, 1'b0, SH_32}; ma = mdre[63:32];          mb = f_q;
            npw_d = pw_scale(acc);
          end
          5'd5: begin
            mctl = '{1'b1, 1'b1, SH_0};  ma = mdim[31:0];            mb = f_q;
          end
          5'd6: begin
            mctl   = '{1'b1, 1'b0, SH_32}; ma = mdim[63:32];         mb = f_q;
            ndre_d = dens_scale(rd_dre[DEN_W-1], acc);
          end
          NRM_LAST: begin
            ram_we    = 1'b1;
            ram_wdata = {npw_q, ndre_q, dens_scale(rd_dim[DEN_W-1], acc)};
            step_d    = '0;
            if (idx_q == LAST_IDX) begin
              idx_d   = '0;
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLR;
      step_q          <= '0;
      idx_q           <= '0;
      valid_q         <= 1'b0;
      kpoint_count_q  <= 11'd1024;
      species_count_q <= 4'd1;
      sum_re_q        <= '0;
      sum_im_q        <= '0;
      wt_q            <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      idx_q    <= idx_d;
      valid_q  <= valid_d;
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      wt_q     <= wt_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_KPOINT_COUNT:  kpoint_count_q  <= cfg_wdata_i;
          REG_SPECIES_COUNT: species_count_q <= cfg_wdata_i[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kaddr_q   <= kaddr_d;
    w_q       <= w_d;
    f_q       <= f_d;
    last_k_q  <= last_k_d;
    oob_q     <= oob_d;
    sq_q      <= sq_d;
    prw_re_q  <= prw_re_d;
    prw_im_q  <= prw_im_d;
    npw_q     <= npw_d;
    ndre_q    <= ndre_d;
    pw_out_q  <= pw_out_d;
    dre_out_q <= dre_out_d;
    dim_out_q <= dim_out_d;
    wt_out_q  <= wt_out_d;
  end

  wsfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KPOINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wsfa_macc u_macc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .a_i    (ma),
    .b_i    (mb),
    .acc_o  (acc)
  );

  assign busy_o             = (state_q != ST_IDLE);
  assign valid_o            = valid_q;
  assign power_sum_o        = pw_out_q;
  assign density_sum_real_o = dre_out_q;
  assign density_sum_imag_o = dim_out_q;
  assign weight_total_o     = wt_out_q;

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  a_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy_o)
    else $error("store written while idle");

  a_read_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_READ) |=> (state_q == ST_RD))
    else $error("read transfer did not enter the read state");

endmodule

### rtl/wsfa_ram.sv
// ----------------------------------------------------------------------------
// wsfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wsfa_macc.sv
// ----------------------------------------------------------------------------
// wsfa_macc
// Shared 32x32 multiplier with a registered product and a 96-bit
// accumulator that adds each product at a 32-bit word offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfa_macc (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wsfa_pkg::macc_ctl_t                  ctl_i,
  input  logic [wsfa_pkg::MUL_W-1:0]           a_i,
  input  logic [wsfa_pkg::MUL_W-1:0]           b_i,
  output logic [wsfa_pkg::ACC_W-1:0]           acc_o
);

  import wsfa_pkg::*;

  macc_ctl_t              ctl_q;
  logic [2*MUL_W-1:0]     prod_q;
  logic [ACC_W-1:0]       acc_q;
  logic [ACC_W-1:0]       addend;

  always_comb begin
    case (ctl_q.shift)
      SH_0:    addend = ACC_W'(prod_q);
      SH_32:   addend = {prod_q, 32'b0};
      SH_64:   addend = {prod_q[MUL_W-1:0], 64'b0};
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      prod_q <= a_i * b_i;
    end
    if (ctl_q.issue) begin
      acc_q <= (ctl_q.clr ? '0 : acc_q) + addend;
    end
  end

  assign acc_o = acc_q;

  a_shift_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.issue |-> (ctl_i.shift == SH_0 || ctl_i.shift == SH_32 || ctl_i.shift == SH_64))
    else $error("unused shift code issued");

  a_clear_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.issue && ctl_q.clr) |=> (acc_q == $past(addend)))
    else $error("accumulator clear did not load the product");

endmodule
